### rtl/mmh64a_pkg.sv
// package: constants, state type and byte-mask helper for the murmur2 64a hash block
`default_nettype none
package mmh64a_pkg;

    localparam logic [63:0] MIX_MUL    = 64'hc6a4a7935bd1e995;
    localparam int          MIX_SHIFT  = 47;
    localparam logic [31:0] SEED_RESET = 32'h0000_0424;

    localparam int WORD_W   = 64;
    localparam int COUNT_W  = 4;
    localparam int LENGTH_W = 32;
    localparam int SEED_W   = 32;
    localparam int HALF_W   = 32;
    localparam int TDATA_W  = 104;

    localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;
    localparam logic [1:0]         PP_LAST    = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LEN,
        S_DATA,
        S_PRE1,
        S_PRE2,
        S_ACC,
        S_TAIL,
        S_FIN
    } t_state;

    function automatic logic [WORD_W-1:0] byte_mask(input logic [COUNT_W-1:0] cnt);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (COUNT_W'(b) < cnt) begin
                m[b*8 +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

    function automatic logic [WORD_W-1:0] xorshift(input logic [WORD_W-1:0] v);
        return v ^ (v >> MIX_SHIFT);
    endfunction

endpackage
`default_nettype wire

### rtl/murmur2_64a_hash.sv
// top level: 64-bit murmur2 (64a) hash over a stream of little-endian message words
//
// One 32x32 multiplier is shared by every multiply by the mixing constant; a 64-bit
// product is built from three partial products summed in a register. The block takes
// one word at a time and drops tready until that word is done: the first word adds
// the length seeding, a full word is scrambled and mixed in, a partial word is masked
// and mixed in, an empty word only passes, and the last word adds finalization before
// the hash appears. The hash sits in an output register, so the next message may start
// while it waits; finalization of a following hash stalls only while the previous one
// is still held.
`default_nettype none
module murmur2_64a_hash (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [mmh64a_pkg::SEED_W-1:0]  i_cfg_wr_data,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // data_word[63:0], valid_bytes[67:64], message_length[99:68], zero pad
    input  wire logic [mmh64a_pkg::TDATA_W-1:0] s_axis_tdata,
    // first_word
    input  wire logic                           s_axis_tuser,
    input  wire logic                           s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // hash_value[63:0]
    output logic [mmh64a_pkg::WORD_W-1:0]       m_axis_tdata
);
    import mmh64a_pkg::*;

    t_state                r_state, n_state;
    logic [SEED_W-1:0]     r_seed;
    logic [WORD_W-1:0]     r_acc, n_acc;
    logic [WORD_W-1:0]     r_op, n_op;
    logic [WORD_W-1:0]     r_prod, n_prod;
    logic [WORD_W-1:0]     r_word, n_word;
    logic [COUNT_W-1:0]    r_cnt, n_cnt;
    logic                  r_last, n_last;
    logic                  r_in_msg, n_in_msg;
    logic [1:0]            r_pp, n_pp;
    logic                  r_out_valid, n_out_valid;
    logic [WORD_W-1:0]     r_out, n_out;

    logic [HALF_W-1:0]     mul_a, mul_b;
    logic [WORD_W-1:0]     mul_p, mul_term, mul_sum;
    logic                  mul_state, mul_done, accept;

    logic [WORD_W-1:0]     in_word;
    logic [COUNT_W-1:0]    in_cnt;
    logic [LENGTH_W-1:0]   in_len;

    assign in_word = s_axis_tdata[WORD_W-1:0];
    assign in_cnt  = s_axis_tdata[WORD_W +: COUNT_W];
    assign in_len  = s_axis_tdata[WORD_W+COUNT_W +: LENGTH_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // shared multiplier: op * MIX_MUL mod 2^64 as three partial products
    assign mul_a    = (r_pp == PP_LAST) ? r_op[WORD_W-1:HALF_W] : r_op[HALF_W-1:0];
    assign mul_b    = (r_pp == 2'd1) ? MIX_MUL[WORD_W-1:HALF_W] : MIX_MUL[HALF_W-1:0];
    assign mul_p    = WORD_W'(mul_a) * WORD_W'(mul_b);
    assign mul_term = (r_pp == 2'd0) ? mul_p : {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};
    assign mul_sum  = ((r_pp == 2'd0) ? '0 : r_prod) + mul_term;
    assign mul_state = (r_state == S_LEN) || (r_state == S_PRE1) || (r_state == S_PRE2)
                    || (r_state == S_ACC) || (r_state == S_FIN);
    assign mul_done = mul_state && (r_pp == PP_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seed      <= SEED_RESET;
            r_acc       <= '0;
            r_in_msg    <= 1'b0;
            r_pp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_in_msg    <= n_in_msg;
            r_pp        <= n_pp;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_seed <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_prod <= n_prod;
        r_word <= n_word;
        r_cnt  <= n_cnt;
        r_last <= n_last;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_op        = r_op;
        n_prod      = r_prod;
        n_word      = r_word;
        n_cnt       = r_cnt;
        n_last      = r_last;
        n_in_msg    = r_in_msg;
        n_pp        = r_pp;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        if (mul_state) begin
            if (r_pp != PP_LAST) begin
                n_prod = mul_sum;
                n_pp   = r_pp + 2'd1;
            end else if (r_state != S_FIN || n_out_valid == 1'b0) begin
                n_pp = '0;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_word = in_word;
                    n_cnt  = in_cnt;
                    n_last = s_axis_tlast;
                    if (s_axis_tuser) begin
                        n_in_msg = 1'b1;
                        n_op     = WORD_W'(in_len);
                        n_state  = S_LEN;
                    end else if (r_in_msg) begin
                        n_state = S_DATA;
                    end
                end
            end
            S_LEN: begin
                if (mul_done) begin
                    n_acc   = WORD_W'(r_seed) ^ mul_sum;
                    n_state = S_DATA;
                end
            end
            S_DATA: begin
                if (r_cnt >= FULL_COUNT) begin
                    n_op    = r_word;
                    n_state = S_PRE1;
                end else if (r_cnt != '0) begin
                    n_op    = r_acc ^ (r_word & byte_mask(r_cnt));
                    n_state = S_ACC;
                end else begin
                    n_state = S_TAIL;
                end
            end
            S_PRE1: begin
                if (mul_done) begin
                    n_op    = xorshift(mul_sum);
                    n_state = S_PRE2;
                end
            end
            S_PRE2: begin
                if (mul_done) begin
                    n_op    = r_acc ^ mul_sum;
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (mul_done) begin
                    n_acc   = mul_sum;
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                if (r_last) begin
                    n_in_msg = 1'b0;
                    n_op     = xorshift(r_acc);
                    n_state  = S_FIN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FIN: begin
                // hold the finished product until the output register is free
                if (mul_done && !n_out_valid) begin
                    n_out       = xorshift(mul_sum);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_busy_in_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_FIN) |-> r_in_msg)
        else $error("word in flight without an open message");

    a_pp_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !mul_state |-> (r_pp == 2'd0))
        else $error("partial product step outside a multiply");

    a_pp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pp != 2'd3)
        else $error("partial product step out of range");

    a_first_seeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s_axis_tuser) |=> (r_state == S_LEN && r_op[WORD_W-1:LENGTH_W] == '0))
        else $error("first word did not start length seeding");

    a_hash_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("hash emitted outside finalization");

endmodule
`default_nettype wire

### tb/testbench.sv
// testbench for the murmur2 64a hash block: stream driver, hash monitor and scoreboard
`timescale 1ns / 1ps
module testbench;

    localparam logic [63:0] HASH_MUL     = 64'hc6a4a7935bd1e995;
    localparam int          HASH_SHIFT   = 47;
    localparam logic [31:0] POWERUP_SEED = 32'h0000_0424;
    localparam int          SETTLE       = 60;
    localparam int          RUN_LIMIT    = 500000;
    localparam int          RANDOM_ITEMS = 550;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic        first;
        logic        last;
        logic [31:0] length;
    } t_word_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [mmh64a_pkg::SEED_W-1:0] i_cfg_wr_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // data_word[63:0], valid_bytes[67:64], message_length[99:68], zero pad
    logic [mmh64a_pkg::TDATA_W-1:0] s_axis_tdata = '0;
    // first_word
    logic s_axis_tuser = 1'b0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // hash_value[63:0]
    logic [mmh64a_pkg::WORD_W-1:0] m_axis_tdata;

    murmur2_64a_hash dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_word_beat  beat_queue[$];
    logic [63:0] hash_queue[$];

    logic [63:0] run_hash = '0;
    logic        run_open = 1'b0;
    logic [31:0] seed_copy = POWERUP_SEED;
    logic        in_fire = 1'b0;

    int cycle_count = 0;
    int error_count = 0;
    int beats_taken = 0;
    int hashes_seen = 0;
    int stim_items = 0;
    int seeds_written = 0;
    int longest_msg = 0;
    int burst_left = 1;
    int gap_left = 0;
    int ready_hold = 0;
    int pick = 0;
    t_word_beat next_beat;

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] scramble_word(input logic [63:0] k);
        k = k * HASH_MUL;
        k = k ^ (k >> HASH_SHIFT);
        k = k * HASH_MUL;
        return k;
    endfunction

    function automatic logic [63:0] finish_hash(input logic [63:0] h);
        h = h ^ (h >> HASH_SHIFT);
        h = h * HASH_MUL;
        h = h ^ (h >> HASH_SHIFT);
        return h;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        error_count++;
    endtask

    task automatic hash_step(input t_word_beat b);
        logic [63:0] mask;
        beats_taken++;
        if (b.first) begin
            run_hash = {32'h0, seed_copy} ^ ({32'h0, b.length} * HASH_MUL);
            run_open = 1'b1;
        end else if (!run_open) begin
            return;
        end
        if (b.count >= 4'd8) begin
            run_hash = (run_hash ^ scramble_word(b.data)) * HASH_MUL;
        end else if (b.count != 4'd0) begin
            mask = (64'h1 << (b.count * 8)) - 64'h1;
            run_hash = (run_hash ^ (b.data & mask)) * HASH_MUL;
        end
        if (b.last) begin
            hash_queue.push_back(finish_hash(run_hash));
            run_open = 1'b0;
        end
    endtask

    // monitor: input beats feed the predictor, output beats are checked
    always @(posedge i_clk) begin
        logic [63:0] want;
        cycle_count++;
        in_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (!i_rst_n) begin
            run_hash = '0;
            run_open = 1'b0;
            seed_copy = POWERUP_SEED;
        end else begin
            if (i_cfg_wr_en) begin
                seed_copy = i_cfg_wr_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                hash_step('{s_axis_tdata[63:0], s_axis_tdata[67:64], s_axis_tuser,
                            s_axis_tlast, s_axis_tdata[99:68]});
            end
            if (m_axis_tvalid && m_axis_tready) begin
                hashes_seen++;
                if (hash_queue.size() == 0) begin
                    report_mismatch($sformatf("hash %h with none expected", m_axis_tdata));
                end else begin
                    want = hash_queue.pop_front();
                    if (m_axis_tdata !== want) begin
                        report_mismatch($sformatf("hash_value got %h want %h",
                                                  m_axis_tdata, want));
                    end
                end
            end
        end
        if (cycle_count == RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d hashes outstanding",
                     cycle_count, hash_queue.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // driver: bursts of beats separated by random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (beat_queue.size() > 0) begin
                next_beat = beat_queue.pop_front();
                s_axis_tdata  <= {4'h0, next_beat.length, next_beat.count, next_beat.data};
                s_axis_tuser  <= next_beat.first;
                s_axis_tlast  <= next_beat.last;
                s_axis_tvalid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: long ready stretches, stalls and short ready blips
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (ready_hold > 0) begin
            ready_hold--;
        end else begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                m_axis_tready <= 1'b1;
                ready_hold = $urandom_range(30, 80);
            end else if (pick < 7) begin
                m_axis_tready <= 1'b0;
                ready_hold = $urandom_range(1, 25);
            end else begin
                m_axis_tready <= 1'b1;
                ready_hold = $urandom_range(0, 4);
            end
        end
    end

    task automatic push_beat(input logic [63:0] data, input logic [3:0] count,
                             input logic first, input logic last,
                             input logic [31:0] length, input bit counted);
        beat_queue.push_back('{data, count, first, last, length});
        if (counted) begin
            stim_items++;
        end
    endtask

    // one message of nbytes; optionally lying length, no closing last, oversize counts, ragged middle words
    task automatic push_message(input int nbytes, input bit true_length, input bit close_it,
                                input bit oversize, input bit ragged);
        int nfull;
        int nwords;
        logic [31:0] len;
        logic [3:0] cnt;
        nfull = nbytes / 8;
        nwords = nfull + ((nbytes % 8 != 0 || nfull == 0) ? 1 : 0);
        len = true_length ? 32'(nbytes) : $urandom();
        if (nbytes > longest_msg) begin
            longest_msg = nbytes;
        end
        for (int i = 0; i < nwords; i++) begin
            if (i < nfull) begin
                cnt = (oversize && $urandom_range(0, 3) == 0) ? 4'($urandom_range(9, 15))
                                                              : 4'd8;
            end else begin
                cnt = 4'(nbytes % 8);
            end
            if (ragged && i < nwords - 1 && $urandom_range(0, 2) == 0) begin
                cnt = 4'($urandom_range(0, 7));
            end
            push_beat(rand64(), cnt, i == 0, close_it && i == nwords - 1, len, 1);
        end
    endtask

    task automatic wait_quiet();
        while (beat_queue.size() != 0 || s_axis_tvalid || hash_queue.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        seeds_written++;
    endtask

    task automatic random_batch(input int items);
        int goal;
        int nbytes;
        int choice;
        goal = stim_items + items;
        while (stim_items < goal) begin
            choice = $urandom_range(0, 99);
            nbytes = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 200)
                                                  : $urandom_range(0, 40);
            if (choice < 70) begin
                push_message(nbytes, $urandom_range(0, 4) != 0, 1,
                             $urandom_range(0, 5) == 0, 0);
            end else if (choice < 78) begin
                push_beat(rand64(), 4'($urandom_range(0, 15)), 1'b0,
                          1'($urandom_range(0, 1)), $urandom(), 0);
            end else if (choice < 86) begin
                push_message(nbytes, 1, 0, 0, 0);
            end else if (choice < 94) begin
                push_message(nbytes, 1, 1, 1, 1);
            end else begin
                push_beat(rand64(), 4'($urandom_range(0, 15)), 1'b1, 1'b1, $urandom(), 1);
            end
        end
        push_message($urandom_range(0, 24), 1, 1, 0, 0);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed beats under the power-up seed
        push_beat(64'h0, 4'd0, 1'b1, 1'b1, 32'h0, 1);
        push_beat(rand64(), 4'd0, 1'b1, 1'b1, 32'hffff_ffff, 1);
        push_beat('1, 4'd8, 1'b1, 1'b1, 32'd8, 1);
        push_beat('1, 4'd15, 1'b1, 1'b1, 32'hffff_ffff, 1);
        for (int n = 1; n < 8; n++) begin
            push_beat('1, 4'(n), 1'b1, 1'b1, 32'(n), 1);
        end
        // idle words without a first marker are dropped
        push_beat(rand64(), 4'd8, 1'b0, 1'b1, $urandom(), 0);
        push_beat(rand64(), 4'd4, 1'b0, 1'b0, $urandom(), 0);
        // partial word in the middle of a message
        push_beat(rand64(), 4'd8, 1'b1, 1'b0, 32'd21, 1);
        push_beat(rand64(), 4'd3, 1'b0, 1'b0, 32'd21, 1);
        push_beat(rand64(), 4'd5, 1'b0, 1'b1, 32'd21, 1);
        // restart on a second first word
        push_beat(rand64(), 4'd8, 1'b1, 1'b0, 32'd16, 1);
        push_beat(rand64(), 4'd8, 1'b1, 1'b0, 32'd16, 1);
        push_beat(rand64(), 4'd8, 1'b0, 1'b1, 32'd16, 1);
        // length that disagrees with the words
        push_beat(rand64(), 4'd8, 1'b1, 1'b0, 32'd3, 1);
        push_beat(rand64(), 4'd2, 1'b0, 1'b1, 32'd3, 1);
        push_beat(64'h0, 4'd8, 1'b1, 1'b1, 32'd8, 1);
        wait_quiet();

        write_seed(32'h0);
        random_batch(RANDOM_ITEMS / 4);
        wait_quiet();
        write_seed(32'hffff_ffff);
        random_batch(RANDOM_ITEMS / 4);
        wait_quiet();
        write_seed($urandom());
        random_batch(RANDOM_ITEMS / 4);
        wait_quiet();
        write_seed($urandom());
        random_batch(RANDOM_ITEMS / 4);
        wait_quiet();

        if (hash_queue.size() != 0) begin
            report_mismatch($sformatf("%0d hashes never arrived", hash_queue.size()));
        end
        $display("%0d beats accepted, %0d hashes compared, %0d seed writes after reset seed",
                 beats_taken, hashes_seen, seeds_written);
        $display("messages up to %0d bytes, valid counts 0..15, dropped idle words, restarts",
                 longest_msg);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### murmur2_64a_hash.f
rtl/mmh64a_pkg.sv
rtl/murmur2_64a_hash.sv
tb/testbench.sv
